FILE: hw/rtl/gfau_pkg.sv
// Shared types, constants and helper functions for the GF(2^m) arithmetic unit.
// No dependencies; used by the top level and by its checker.

package gfau_pkg;

    // Field element and table geometry.
    localparam int MAX_FIELD_BITS = 12;
    localparam int DATA_W         = MAX_FIELD_BITS;
    localparam int TABLE_DEPTH    = 1 << MAX_FIELD_BITS;
    localparam int M_W            = 4;
    localparam int POLY_W         = 13;
    localparam int PROD_W         = 2 * DATA_W;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = POLY_W;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_BITS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REDUCTION_POLY = 1'b1;

    // Reset configuration.
    localparam logic [M_W-1:0]    RESET_FIELD_BITS = 4'd8;
    localparam logic [POLY_W-1:0] RESET_POLY       = '0;

    // Opcodes.
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_MUL = 2'd0;
    localparam logic [OP_W-1:0] OP_DIV = 2'd1;
    localparam logic [OP_W-1:0] OP_POW = 2'd2;

    // Table rebuild sequencer states.
    typedef enum logic [2:0] {
        SEQ_IDLE  = 3'b001,
        SEQ_CLEAR = 3'b010,
        SEQ_BUILD = 3'b100
    } t_seq_state;

    // Clamp the configured width into the supported range.
    function automatic logic [M_W-1:0] eff_bits(input logic [M_W-1:0] fb);
        logic [M_W-1:0] m;
        m = fb;
        if (fb < 4'd2) begin
            m = 4'd2;
        end else if (fb > M_W'(MAX_FIELD_BITS)) begin
            m = M_W'(MAX_FIELD_BITS);
        end
        return m;
    endfunction

    // Mask of the low m bits, which is also the multiplicative group order.
    function automatic logic [DATA_W-1:0] field_mask(input logic [M_W-1:0] m);
        logic [DATA_W:0] one_hot;
        one_hot = (DATA_W+1)'(1) << m;
        return DATA_W'(one_hot - (DATA_W+1)'(1));
    endfunction

    // Built-in primitive polynomial for each supported width.
    function automatic logic [POLY_W-1:0] default_poly(input logic [M_W-1:0] m);
        logic [POLY_W-1:0] p;
        unique case (m)
            4'd2:    p = 13'h0007;
            4'd3:    p = 13'h000B;
            4'd4:    p = 13'h0013;
            4'd5:    p = 13'h0025;
            4'd6:    p = 13'h0043;
            4'd7:    p = 13'h0089;
            4'd8:    p = 13'h0187;
            4'd9:    p = 13'h0211;
            4'd10:   p = 13'h0409;
            4'd11:   p = 13'h0805;
            4'd12:   p = 13'h1053;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

FILE: hw/rtl/gfau_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the log and antilog tables.

module gfau_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; the data holds while the read is not enabled.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/gf2m_arithmetic_unit.sv
// Pipeline: five register stages (log lookup, log sum or product, fold, reduction and antilog, output).
// Throughput: one item per cycle unless rebuilding or output-stalled; bubbles collapse on a stall.
// After each register write the log and antilog memories are rebuilt, one entry a cycle,
// in a clear sweep, then a build sweep; the input stalls meanwhile.
// Reset is synchronous and active low: it loads m = 8 with the default polynomial and
// starts that rebuild, so the input stalls after reset until the rebuild ends.

module gf2m_arithmetic_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port.
    input  logic                             i_cfg_wr_en,
    input  logic [gfau_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gfau_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Input channel.
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [gfau_pkg::OP_W-1:0]        i_opcode,
    input  logic [gfau_pkg::DATA_W-1:0]      i_operand_a,
    input  logic [gfau_pkg::DATA_W-1:0]      i_operand_b,
    // Output channel.
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [gfau_pkg::DATA_W-1:0]      o_result
);

    import gfau_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    // Configuration registers.
    logic [M_W-1:0]    r_field_bits;
    logic [POLY_W-1:0] r_poly;

    // Derived field parameters.
    logic [M_W-1:0]    w_m;
    logic [DATA_W-1:0] w_mask;
    logic [DATA_W-1:0] w_poly;
    logic [POLY_W-1:0] w_poly_src;

    assign w_m        = eff_bits(r_field_bits);
    assign w_mask     = field_mask(w_m);
    assign w_poly_src = (r_poly == '0) ? default_poly(w_m) : r_poly;
    assign w_poly     = w_poly_src[DATA_W-1:0] & w_mask;

    // Rebuild sequencer.
    t_seq_state        r_state, n_state;
    logic [DATA_W-1:0] r_cnt, n_cnt;
    logic [DATA_W-1:0] r_pow, n_pow;
    logic [POLY_W-1:0] w_shift;
    logic              w_carry;
    logic [DATA_W-1:0] w_next_pow;
    logic              w_busy;

    // Next power of alpha: shift left, reduce on carry out of m bits.
    assign w_shift    = {r_pow, 1'b0};
    assign w_carry    = w_shift[w_m];
    assign w_next_pow = (w_shift[DATA_W-1:0] ^ (w_carry ? w_poly : '0)) & w_mask;
    assign w_busy     = (r_state != SEQ_IDLE);

    // Memory write ports driven by the sequencer.
    logic              w_log_we;
    logic [ADDR_W-1:0] w_log_waddr;
    logic [DATA_W-1:0] w_log_wdata;
    logic              w_alog_we;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pow       = r_pow;
        w_log_we    = 1'b0;
        w_log_waddr = r_cnt;
        w_log_wdata = '0;
        w_alog_we   = 1'b0;
        unique case (r_state)
            SEQ_IDLE: begin
            end
            SEQ_CLEAR: begin
                w_log_we = 1'b1;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == w_mask) begin
                    n_state = SEQ_BUILD;
                    n_cnt   = '0;
                    n_pow   = DATA_W'(1);
                end
            end
            SEQ_BUILD: begin
                // The entry for one stays at zero from the clear sweep.
                w_alog_we   = 1'b1;
                w_log_we    = (r_pow != DATA_W'(1));
                w_log_waddr = r_pow;
                w_log_wdata = r_cnt;
                n_cnt       = r_cnt + 1'b1;
                n_pow       = w_next_pow;
                if (r_cnt == w_mask) begin
                    n_state = SEQ_IDLE;
                end
            end
            default: begin
                n_state = SEQ_CLEAR;
                n_cnt   = '0;
            end
        endcase
        // A register write restarts the rebuild.
        if (i_cfg_wr_en) begin
            n_state = SEQ_CLEAR;
            n_cnt   = '0;
        end
    end

    // Configuration and sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_bits <= RESET_FIELD_BITS;
            r_poly       <= RESET_POLY;
            r_state      <= SEQ_CLEAR;
            r_cnt        <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_FIELD_BITS:     r_field_bits <= i_cfg_data[M_W-1:0];
                    CFG_REDUCTION_POLY: r_poly       <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pow <= n_pow;
    end

    // Pipeline valid bits and stage enables.
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_en1, w_en2, w_en3, w_en4, w_en5;
    logic w_accept;

    assign w_en5    = !r_v5 || !i_out_stall;
    assign w_en4    = !r_v4 || w_en5;
    assign w_en3    = !r_v3 || w_en4;
    assign w_en2    = !r_v2 || w_en3;
    assign w_en1    = !r_v1 || w_en2;
    assign o_in_stall = w_busy || !w_en1;
    assign w_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= w_accept;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= r_v4;
        end
    end

    // Stage 1: mask the operands and look up both logs.
    logic [DATA_W-1:0] w_a, w_b;
    logic [DATA_W-1:0] w_log_a, w_log_b;
    logic [OP_W-1:0]   r1_op;
    logic              r1_a_nz, r1_b_nz;
    logic [DATA_W-1:0] r1_b;

    assign w_a = i_operand_a & w_mask;
    assign w_b = i_operand_b & w_mask;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_op   <= i_opcode;
            r1_a_nz <= (w_a != '0);
            r1_b_nz <= (w_b != '0);
            r1_b    <= w_b;
        end
    end

    gfau_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_log_a (
        .i_clk     (i_clk),
        .i_wr_en   (w_log_we),
        .i_wr_addr (w_log_waddr),
        .i_wr_data (w_log_wdata),
        .i_rd_en   (w_en1),
        .i_rd_addr (w_a),
        .o_rd_data (w_log_a)
    );

    gfau_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_log_b (
        .i_clk     (i_clk),
        .i_wr_en   (w_log_we),
        .i_wr_addr (w_log_waddr),
        .i_wr_data (w_log_wdata),
        .i_rd_en   (w_en1),
        .i_rd_addr (w_b),
        .o_rd_data (w_log_b)
    );

    // Stage 2: exponent product, log sum or difference, and zero-operand overrides.
    logic [DATA_W-1:0] w_b_red;
    logic [POLY_W-1:0] w_sum;
    logic              w_force, w_fval;
    logic [PROD_W-1:0] r2_prod;
    logic [POLY_W-1:0] r2_sum;
    logic              r2_pow, r2_force, r2_fval;

    // The exponent only matters modulo the group order.
    assign w_b_red = (r1_b == w_mask) ? '0 : r1_b;

    always_comb begin
        w_force = 1'b1;
        w_fval  = 1'b0;
        if (r1_op == OP_DIV) begin
            w_sum = POLY_W'(w_log_a) + POLY_W'(w_mask) - POLY_W'(w_log_b);
        end else begin
            w_sum = POLY_W'(w_log_a) + POLY_W'(w_log_b);
        end
        unique case (r1_op)
            OP_MUL, OP_DIV: begin
                w_force = !(r1_a_nz && r1_b_nz);
            end
            OP_POW: begin
                // Zero to the power zero is one; zero to any other power is zero.
                w_force = !r1_a_nz;
                w_fval  = !r1_b_nz;
            end
            default: begin
                w_force = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_prod  <= PROD_W'(w_log_a) * PROD_W'(w_b_red);
            r2_sum   <= w_sum;
            r2_pow   <= (r1_op == OP_POW);
            r2_force <= w_force;
            r2_fval  <= w_fval;
        end
    end

    // Stage 3: fold the product once modulo 2^m - 1.
    logic [DATA_W-1:0] w_hi;
    logic [POLY_W-1:0] w_fold;
    logic [POLY_W-1:0] r3_t;
    logic              r3_force, r3_fval;

    assign w_hi   = DATA_W'(r2_prod >> w_m);
    assign w_fold = POLY_W'(w_hi) + POLY_W'(r2_prod[DATA_W-1:0] & w_mask);

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_t     <= r2_pow ? w_fold : r2_sum;
            r3_force <= r2_force;
            r3_fval  <= r2_fval;
        end
    end

    // Stage 4: final reduction (value is at most twice the order) and antilog lookup.
    logic [POLY_W-1:0] w_order2;
    logic [POLY_W-1:0] w_red;
    logic [DATA_W-1:0] w_alog;
    logic              r4_force, r4_fval;

    assign w_order2 = {w_mask, 1'b0};

    always_comb begin
        if (r3_t >= w_order2) begin
            w_red = r3_t - w_order2;
        end else if (r3_t >= POLY_W'(w_mask)) begin
            w_red = r3_t - POLY_W'(w_mask);
        end else begin
            w_red = r3_t;
        end
    end

    gfau_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_antilog (
        .i_clk     (i_clk),
        .i_wr_en   (w_alog_we),
        .i_wr_addr (r_cnt),
        .i_wr_data (r_pow),
        .i_rd_en   (w_en4),
        .i_rd_addr (w_red[DATA_W-1:0]),
        .o_rd_data (w_alog)
    );

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r4_force <= r3_force;
            r4_fval  <= r3_fval;
        end
    end

    // Stage 5: output register.
    logic [DATA_W-1:0] r_result;

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r_result <= r4_force ? DATA_W'(r4_fval) : w_alog;
        end
    end

    assign o_out_valid = r_v5;
    assign o_result    = r_result;

endmodule

FILE: hw/rtl/gfau_checker.sv
// Port-level checker for the GF(2^m) arithmetic unit, bound to the top level.
// Depends on gfau_pkg and on gf2m_arithmetic_unit.

module gfau_props (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_wr_en,
    input logic [gfau_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [gfau_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic [gfau_pkg::OP_W-1:0]        i_opcode,
    input logic [gfau_pkg::DATA_W-1:0]      i_operand_a,
    input logic [gfau_pkg::DATA_W-1:0]      i_operand_b,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [gfau_pkg::DATA_W-1:0]      o_result
);

    import gfau_pkg::*;

    // Reset empties the pipeline and starts a table rebuild.
    a_reset_rebuild: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("input not stalled or output valid after reset");

    // Even the smallest field keeps the input stalled while it rebuilds after a register write.
    a_cfg_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> o_in_stall ##1 o_in_stall ##1 o_in_stall ##1 o_in_stall
                        ##1 o_in_stall ##1 o_in_stall ##1 o_in_stall ##1 o_in_stall)
        else $error("input accepted during table rebuild");

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result))
        else $error("stalled result dropped or changed");

endmodule

bind gf2m_arithmetic_unit gfau_props u_gfau_props (.*);
